FILE: design/ase_pkg.sv
// shared types and constants of the ascending sort engine
package ase_pkg;

	localparam int MAX_ITEMS = 16;
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

	localparam logic [CNT_W-1:0] MAX_CNT    = CNT_W'(MAX_ITEMS);
	localparam logic [CNT_W-1:0] DRAIN_LAST = CNT_W'(MAX_ITEMS - 1);
	localparam logic [CNT_W-1:0] CNT_ONE    = CNT_W'(1);

	typedef struct packed {
		logic signed [31:0] sample;
		logic               final_item;
	} item_t;

	typedef struct packed {
		logic signed [31:0] sorted_value;
		logic               end_of_run;
		logic               dropped_some;
	} result_t;

	// one value moving between neighbouring cells
	typedef struct packed {
		logic               valid;
		logic signed [31:0] value;
	} lane_t;

endpackage

FILE: design/ase_cell.sv
// one sorting cell: keeps the smaller value, hands the larger on, shifts left on unload
module ase_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          shift,
	input  ase_pkg::lane_t in_lane,
	input  ase_pkg::lane_t nbr,
	output ase_pkg::lane_t held,
	output ase_pkg::lane_t pass
);

	logic held_valid_q;
	logic pass_valid_q;
	logic signed [31:0] held_value_q;
	logic signed [31:0] pass_value_q;
	logic take_in;

	// incoming value stays here when the cell is empty or it is strictly smaller
	assign take_in = in_lane.valid && (!held_valid_q || (in_lane.value < held_value_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			pass_valid_q <= 1'b0;
		end else if (shift) begin
			held_valid_q <= nbr.valid;
			pass_valid_q <= 1'b0;
		end else begin
			if (in_lane.valid && !held_valid_q)
				held_valid_q <= 1'b1;
			pass_valid_q <= in_lane.valid && held_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			held_value_q <= nbr.value;
		end else if (take_in) begin
			held_value_q <= in_lane.value;
		end
		if (take_in)
			pass_value_q <= held_value_q;
		else
			pass_value_q <= in_lane.value;
	end

	assign held = '{valid: held_valid_q, value: held_value_q};
	assign pass = '{valid: pass_valid_q, value: pass_value_q};

endmodule

FILE: design/ascending_sort_engine_top.sv
// top level of the ascending sort engine: cell chain, run control and result register
// loading: one value per cycle, busy stays low until the last item of a run is taken
// after the last item: drain state, then unload state; each unload cycle loads the result register and strobe
// unloading: one result per cycle on consecutive cycles, n results for n held values
// reset clears all control and valid bits; results cannot be stalled by the receiver
module ascending_sort_engine_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  ase_pkg::item_t   item,
	output logic            result_strobe,
	output ase_pkg::result_t result
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_DRAIN = 2'd1;
	localparam logic [1:0] ST_EMIT  = 2'd2;

	logic [1:0] state_q;
	logic [ase_pkg::CNT_W-1:0] fill_q;
	logic [ase_pkg::CNT_W-1:0] drain_q;
	logic [ase_pkg::CNT_W-1:0] remain_q;
	logic overflow_q;
	logic strobe_q;
	ase_pkg::result_t result_q;

	logic accept;
	logic shift;

	ase_pkg::lane_t chain_in   [ase_pkg::MAX_ITEMS];
	ase_pkg::lane_t chain_nbr  [ase_pkg::MAX_ITEMS];
	ase_pkg::lane_t chain_held [ase_pkg::MAX_ITEMS];
	ase_pkg::lane_t chain_pass [ase_pkg::MAX_ITEMS];

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign shift  = (state_q == ST_EMIT);

	// cell chain: values walk right while loading, the whole row shifts left while unloading
	genvar gi;
	generate
		for (gi = 0; gi < ase_pkg::MAX_ITEMS; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				// a value beyond capacity never enters the chain
				assign chain_in[gi] = '{valid: accept && (fill_q < ase_pkg::MAX_CNT),
					value: item.sample};
			end else begin : g_body
				assign chain_in[gi] = chain_pass[gi-1];
			end
			if (gi == ase_pkg::MAX_ITEMS - 1) begin : g_tail
				assign chain_nbr[gi] = '0;
			end else begin : g_inner
				assign chain_nbr[gi] = chain_held[gi+1];
			end
			ase_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift   (shift),
				.in_lane (chain_in[gi]),
				.nbr     (chain_nbr[gi]),
				.held    (chain_held[gi]),
				.pass    (chain_pass[gi])
			);
		end
	endgenerate

	// run control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			drain_q    <= '0;
			remain_q   <= '0;
			overflow_q <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			// every unload cycle puts one result on the ports
			strobe_q <= (state_q == ST_EMIT);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (fill_q < ase_pkg::MAX_CNT)
							fill_q <= fill_q + ase_pkg::CNT_ONE;
						else
							overflow_q <= 1'b1;
						if (item.final_item) begin
							state_q <= ST_DRAIN;
							drain_q <= '0;
						end
					end
				end
				ST_DRAIN: begin
					// wait until the last value has settled at the far end of the chain
					if (drain_q == ase_pkg::DRAIN_LAST) begin
						state_q  <= ST_EMIT;
						remain_q <= fill_q;
					end else begin
						drain_q <= drain_q + ase_pkg::CNT_ONE;
					end
				end
				ST_EMIT: begin
					remain_q <= remain_q - ase_pkg::CNT_ONE;
					if (remain_q == ase_pkg::CNT_ONE) begin
						state_q    <= ST_IDLE;
						fill_q     <= '0;
						overflow_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register: during unloading the head cell holds the smallest remaining value
	always_ff @(posedge clk) begin
		if (shift) begin
			result_q.sorted_value <= chain_held[0].value;
			result_q.end_of_run   <= (remain_q == ase_pkg::CNT_ONE);
			result_q.dropped_some <= overflow_q;
		end
	end

	assign result_strobe = strobe_q;
	assign result        = result_q;

	// a result only follows an unload cycle
	a_strobe_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(state_q == ST_EMIT))
		else $error("result transfer without unload cycle");

	// unloading never runs past the held values
	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (remain_q != '0) && chain_held[0].valid)
		else $error("unload with an empty chain");

	// nothing may fall off the far end of the chain
	a_no_spill: assert property (@(posedge clk) disable iff (!arst_n)
		!chain_pass[ase_pkg::MAX_ITEMS-1].valid)
		else $error("value lost at end of chain");

	// the final result of a run returns the engine to idle with an empty chain
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && result.end_of_run) |-> (state_q == ST_IDLE) && !chain_held[0].valid
		&& (fill_q == '0))
		else $error("run not closed after last result");

endmodule
